// ===== rtl/core/uart_16550_register_file_defines.svh =====
// Assertion macros for the 16550-class UART register file.
// Included by the top level; the checks use the i_clk clock and the i_rst_n reset.
// The checks compile only when SYNTHESIS is not defined.
`ifndef UART_16550_REGISTER_FILE_DEFINES_SVH
`define UART_16550_REGISTER_FILE_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define UARTRF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("uart register file check failed");

// The expression must never be true outside reset.
`define UARTRF_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("uart register file forbidden condition seen");

`else

`define UARTRF_ASSERT(lbl, prop)
`define UARTRF_NEVER(lbl, expr)

`endif

`endif

// ===== rtl/core/uart_rf_pkg.sv =====
// Shared types, codes and a helper function of the 16550-class UART register file.
// This file has no dependencies; the top level imports it.
package uart_rf_pkg;

    // Transaction kinds on the input channel.
    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RX      = 2'd2,
        CMD_TX_DONE = 2'd3
    } t_cmd;

    // Register offsets.
    localparam logic [2:0] OFF_RBR_THR = 3'd0;
    localparam logic [2:0] OFF_IER     = 3'd1;
    localparam logic [2:0] OFF_IIR_FCR = 3'd2;
    localparam logic [2:0] OFF_LCR     = 3'd3;
    localparam logic [2:0] OFF_MCR     = 3'd4;
    localparam logic [2:0] OFF_LSR     = 3'd5;
    localparam logic [2:0] OFF_MSR     = 3'd6;
    localparam logic [2:0] OFF_SCR     = 3'd7;

    // Interrupt identification codes, highest priority first.
    localparam logic [2:0] IIR_RLS  = 3'd6;
    localparam logic [2:0] IIR_RDA  = 3'd4;
    localparam logic [2:0] IIR_THRE = 3'd2;
    localparam logic [2:0] IIR_NONE = 3'd1;

    // Interrupt enable bit positions.
    localparam int unsigned IER_RDA_BIT  = 0;
    localparam int unsigned IER_THRE_BIT = 1;
    localparam int unsigned IER_RLS_BIT  = 2;

    // Line control bit that switches offsets 0 and 1 to the divisor latch.
    localparam int unsigned LCR_DLAB_BIT = 7;

    localparam int unsigned IER_W = 4;
    localparam int unsigned MCR_W = 5;
    localparam int unsigned ERR_W = 4;

    // Highest-priority pending interrupt for the given state.
    function automatic logic [2:0] int_ident(
        input logic [IER_W-1:0] ier,
        input logic [ERR_W-1:0] err,
        input logic             dr,
        input logic             thre_pend
    );
        logic [2:0] code;
        code = IIR_NONE;
        if (ier[IER_RLS_BIT] && (err != '0)) begin
            code = IIR_RLS;
        end else if (ier[IER_RDA_BIT] && dr) begin
            code = IIR_RDA;
        end else if (ier[IER_THRE_BIT] && thre_pend) begin
            code = IIR_THRE;
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/uart_16550_register_file.sv =====
// Top level of the 16550-class UART register file in non-FIFO mode.
// Depends on uart_rf_pkg and on the assertion macros in uart_16550_register_file_defines.svh.
`include "uart_16550_register_file_defines.svh"

// This block holds the register file of a 16550-class UART without FIFOs.
// Every input transaction is a bus read, a bus write, a byte arriving from
// the receiver with its error flags, or a notice that the transmit shifter
// finished its byte. Every input transaction produces exactly one output
// transaction that carries the read data (zero for anything but a read),
// the interrupt line, a transmit hand-off strobe with its byte, the baud
// divisor and the line format bits, all as they stand after that
// transaction. The block accepts one transaction per clock cycle for as long
// as the output side keeps taking results. A transaction is captured in an
// input register, evaluated against the register state in shallow
// combinational logic and written into the output register, where the
// result is presented until the output side takes it. The output register
// parts the two channels: a new transaction is taken while a result waits,
// and the input stall rises only when the input register holds a
// transaction and the output register is full and stalled. Reading LSR
// clears the error bits, reading IIR while it reports the THRE code clears
// that interrupt, and reading RBR clears data ready; the modem status
// register reads as zero.
module uart_16550_register_file
    import uart_rf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [2:0]  i_reg_offset,
    input  logic [7:0]  i_wdata,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_parity_error,
    input  logic        i_rx_framing_error,
    input  logic        i_rx_break,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_rdata,
    output logic        o_irq,
    output logic        o_tx_start,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_divisor,
    output logic [6:0]  o_line_format
);

    // Input register.
    logic       r_s1_valid;
    logic [1:0] r_s1_cmd;
    logic [2:0] r_s1_offset;
    logic [7:0] r_s1_wdata;
    logic [7:0] r_s1_rx_byte;
    logic       r_s1_pe;
    logic       r_s1_fe;
    logic       r_s1_brk;

    // Register state of the UART.
    logic [7:0]       r_rx_holding;
    logic [7:0]       r_tx_holding;
    logic             r_tx_full;
    logic             r_tx_shifting;
    logic [IER_W-1:0] r_ier;
    logic [7:0]       r_lcr;
    logic [MCR_W-1:0] r_mcr;
    logic [7:0]       r_scratch;
    logic [7:0]       r_dll;
    logic [7:0]       r_dlm;
    logic             r_dr;
    logic [ERR_W-1:0] r_err;
    logic             r_thre_pending;

    // Next state.
    logic [7:0]       n_rx_holding;
    logic [7:0]       n_tx_holding;
    logic             n_tx_full;
    logic             n_tx_shifting;
    logic [IER_W-1:0] n_ier;
    logic [7:0]       n_lcr;
    logic [MCR_W-1:0] n_mcr;
    logic [7:0]       n_scratch;
    logic [7:0]       n_dll;
    logic [7:0]       n_dlm;
    logic             n_dr;
    logic [ERR_W-1:0] n_err;
    logic             n_thre_pending;

    // Output register and its next values.
    logic       r_out_valid;
    logic [7:0] r_rdata;
    logic       r_irq;
    logic       r_tx_start;
    logic [7:0] r_tx_byte;
    logic [7:0] n_rdata;
    logic       n_tx_start;
    logic [7:0] n_tx_byte;
    logic       n_irq;

    logic       dlab;
    logic       thre;
    logic       temt;
    logic [7:0] lsr;
    logic [2:0] cur_iid;

    // The input register moves on whenever the output register is empty or
    // being taken in this cycle. The state is updated by exactly the
    // transactions that move on, in the order they arrived.
    logic advance;
    logic consume;
    logic accept;

    assign advance    = !r_out_valid || !i_out_stall;
    assign consume    = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Status views of the current state.
    assign dlab    = r_lcr[LCR_DLAB_BIT];
    assign thre    = !r_tx_full;
    assign temt    = thre && !r_tx_shifting;
    assign lsr     = {1'b0, temt, thre, r_err, r_dr};
    assign cur_iid = int_ident(r_ier, r_err, r_dr, r_thre_pending);

    always_comb begin
        n_rx_holding   = r_rx_holding;
        n_tx_holding   = r_tx_holding;
        n_tx_full      = r_tx_full;
        n_tx_shifting  = r_tx_shifting;
        n_ier          = r_ier;
        n_lcr          = r_lcr;
        n_mcr          = r_mcr;
        n_scratch      = r_scratch;
        n_dll          = r_dll;
        n_dlm          = r_dlm;
        n_dr           = r_dr;
        n_err          = r_err;
        n_thre_pending = r_thre_pending;
        n_rdata        = 8'd0;
        n_tx_start     = 1'b0;
        n_tx_byte      = 8'd0;

        case (t_cmd'(r_s1_cmd))
            CMD_READ: begin
                case (r_s1_offset)
                    OFF_RBR_THR: begin
                        if (dlab) begin
                            n_rdata = r_dll;
                        end else begin
                            n_rdata = r_rx_holding;
                            n_dr    = 1'b0;
                        end
                    end
                    OFF_IER: begin
                        n_rdata = dlab ? r_dlm : {{(8-IER_W){1'b0}}, r_ier};
                    end
                    OFF_IIR_FCR: begin
                        n_rdata = {5'd0, cur_iid};
                        if (cur_iid == IIR_THRE) begin
                            n_thre_pending = 1'b0;
                        end
                    end
                    OFF_LCR: n_rdata = r_lcr;
                    OFF_MCR: n_rdata = {{(8-MCR_W){1'b0}}, r_mcr};
                    OFF_LSR: begin
                        n_rdata = lsr;
                        n_err   = '0;
                    end
                    OFF_MSR: n_rdata = 8'd0;
                    OFF_SCR: n_rdata = r_scratch;
                    default: n_rdata = 8'd0;
                endcase
            end
            CMD_WRITE: begin
                case (r_s1_offset)
                    OFF_RBR_THR: begin
                        if (dlab) begin
                            n_dll = r_s1_wdata;
                        end else begin
                            n_tx_holding   = r_s1_wdata;
                            n_tx_full      = 1'b1;
                            n_thre_pending = 1'b0;
                            // An idle shifter takes the byte at once.
                            if (!r_tx_shifting) begin
                                n_tx_start     = 1'b1;
                                n_tx_byte      = r_s1_wdata;
                                n_tx_shifting  = 1'b1;
                                n_tx_full      = 1'b0;
                                n_thre_pending = 1'b1;
                            end
                        end
                    end
                    OFF_IER: begin
                        if (dlab) begin
                            n_dlm = r_s1_wdata;
                        end else begin
                            // Enabling the THRE interrupt with THR empty raises it.
                            if (r_s1_wdata[IER_THRE_BIT] && !r_ier[IER_THRE_BIT] &&
                                !r_tx_full) begin
                                n_thre_pending = 1'b1;
                            end
                            n_ier = r_s1_wdata[IER_W-1:0];
                        end
                    end
                    OFF_LCR: n_lcr     = r_s1_wdata;
                    OFF_MCR: n_mcr     = r_s1_wdata[MCR_W-1:0];
                    OFF_SCR: n_scratch = r_s1_wdata;
                    default: ;
                endcase
            end
            CMD_RX: begin
                // A byte over unread data is an overrun.
                n_err        = r_err | {r_s1_brk, r_s1_fe, r_s1_pe, r_dr};
                n_rx_holding = r_s1_rx_byte;
                n_dr         = 1'b1;
            end
            CMD_TX_DONE: begin
                if (r_tx_shifting) begin
                    if (r_tx_full) begin
                        n_tx_start     = 1'b1;
                        n_tx_byte      = r_tx_holding;
                        n_tx_full      = 1'b0;
                        n_thre_pending = 1'b1;
                    end else begin
                        n_tx_shifting = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        n_irq = (int_ident(n_ier, n_err, n_dr, n_thre_pending) != IIR_NONE);
    end

    // Control and register state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_rx_holding   <= 8'd0;
            r_tx_holding   <= 8'd0;
            r_tx_full      <= 1'b0;
            r_tx_shifting  <= 1'b0;
            r_ier          <= '0;
            r_lcr          <= 8'd0;
            r_mcr          <= '0;
            r_scratch      <= 8'd0;
            r_dll          <= 8'd0;
            r_dlm          <= 8'd0;
            r_dr           <= 1'b0;
            r_err          <= '0;
            r_thre_pending <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (consume) begin
                r_s1_valid <= 1'b0;
            end

            if (consume) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (consume) begin
                r_rx_holding   <= n_rx_holding;
                r_tx_holding   <= n_tx_holding;
                r_tx_full      <= n_tx_full;
                r_tx_shifting  <= n_tx_shifting;
                r_ier          <= n_ier;
                r_lcr          <= n_lcr;
                r_mcr          <= n_mcr;
                r_scratch      <= n_scratch;
                r_dll          <= n_dll;
                r_dlm          <= n_dlm;
                r_dr           <= n_dr;
                r_err          <= n_err;
                r_thre_pending <= n_thre_pending;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd     <= i_cmd;
            r_s1_offset  <= i_reg_offset;
            r_s1_wdata   <= i_wdata;
            r_s1_rx_byte <= i_rx_byte;
            r_s1_pe      <= i_rx_parity_error;
            r_s1_fe      <= i_rx_framing_error;
            r_s1_brk     <= i_rx_break;
        end
        if (consume) begin
            r_rdata    <= n_rdata;
            r_irq      <= n_irq;
            r_tx_start <= n_tx_start;
            r_tx_byte  <= n_tx_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rdata       = r_rdata;
    assign o_irq         = r_irq;
    assign o_tx_start    = r_tx_start;
    assign o_tx_byte     = r_tx_byte;
    // Divisor and line format come straight from the state, which changes
    // only together with the output register.
    assign o_divisor     = {r_dlm, r_dll};
    assign o_line_format = r_lcr[6:0];

    // The input side stalls only behind a full, stalled output register.
    `UARTRF_ASSERT(a_stall_cause, o_in_stall |-> (o_out_valid && i_out_stall))
    // A pending THRE interrupt means the holding register is empty.
    `UARTRF_NEVER(a_thre_empty, r_thre_pending && r_tx_full)
    // A shown hand-off leaves the shifter busy and the holding register empty.
    `UARTRF_ASSERT(a_tx_handoff, (o_out_valid && o_tx_start) |-> (r_tx_shifting && !r_tx_full))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the 16550-class UART register file in non-FIFO mode.
// Depends on uart_rf_pkg and on the uart_16550_register_file top level; nothing else.
// A clocked driver and monitor run against an in-bench register model of the UART.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uart_rf_pkg::*;

    // Clocking and reset. The period is 20 ns.
    localparam int unsigned RESET_CYCLES  = 3;

    // The stimulus is a short directed opening followed by random transactions.
    localparam int unsigned RANDOM_ITEMS  = 625;

    // In the last part of the run neither side idles, so the block runs at full rate.
    localparam int unsigned QUIET_TAIL    = 100;

    // Once this many transactions are in, the receiver stops taking results for a
    // long stretch while the sender keeps offering, so the input side backs up.
    localparam int unsigned LONG_HOLD_AT  = 300;
    localparam int unsigned LONG_HOLD_LEN = 60;

    // The drain at the end of the run catches anything stray.
    localparam int unsigned DRAIN_CYCLES  = 8;

    // Hard stop, well beyond the slowest correct run.
    localparam int unsigned TIMEOUT_NS    = 5_000_000;

    // Error flag positions inside the model's error register.
    localparam int unsigned ERR_OVERRUN = 0;
    localparam int unsigned ERR_PARITY  = 1;
    localparam int unsigned ERR_FRAMING = 2;
    localparam int unsigned ERR_BREAK   = 3;

    // One input transaction as the bus or the line side presents it.
    typedef struct {
        t_cmd       cmd;
        logic [2:0] offset;
        logic [7:0] wdata;
        logic [7:0] rx_byte;
        logic       rx_parity;
        logic       rx_framing;
        logic       rx_brk;
    } t_uart_event;

    // One result transaction as the block reports it.
    typedef struct {
        logic [7:0]  rdata;
        logic        irq;
        logic        tx_start;
        logic [7:0]  tx_byte;
        logic [15:0] divisor;
        logic [6:0]  line_format;
    } t_reg_snapshot;

    // Ports of the block. Every input starts at a known value.
    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd              = '0;
    logic [2:0]  i_reg_offset       = '0;
    logic [7:0]  i_wdata            = '0;
    logic [7:0]  i_rx_byte          = '0;
    logic        i_rx_parity_error  = 1'b0;
    logic        i_rx_framing_error = 1'b0;
    logic        i_rx_break         = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall        = 1'b0;
    logic [7:0]  o_rdata;
    logic        o_irq;
    logic        o_tx_start;
    logic [7:0]  o_tx_byte;
    logic [15:0] o_divisor;
    logic [6:0]  o_line_format;

    uart_16550_register_file dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_reg_offset       (i_reg_offset),
        .i_wdata            (i_wdata),
        .i_rx_byte          (i_rx_byte),
        .i_rx_parity_error  (i_rx_parity_error),
        .i_rx_framing_error (i_rx_framing_error),
        .i_rx_break         (i_rx_break),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_rdata            (o_rdata),
        .o_irq              (o_irq),
        .o_tx_start         (o_tx_start),
        .o_tx_byte          (o_tx_byte),
        .o_divisor          (o_divisor),
        .o_line_format      (o_line_format)
    );

    always #10 i_clk = ~i_clk;

    // Register model of the UART. Reset leaves everything at zero, and reset is
    // applied exactly once, so the declaration values are the reset state.
    logic [7:0] rbr_q        = '0;
    logic [7:0] thr_q        = '0;
    logic       thr_full     = 1'b0;
    logic       shifter_busy = 1'b0;
    logic [3:0] ier_q        = '0;
    logic [7:0] lcr_q        = '0;
    logic [4:0] mcr_q        = '0;
    logic [7:0] scr_q        = '0;
    logic [7:0] dll_q        = '0;
    logic [7:0] dlm_q        = '0;
    logic       rx_ready     = 1'b0;
    logic [3:0] err_q        = '0;
    logic       thre_int     = 1'b0;

    // Transactions waiting to be driven, and results the block still owes us.
    t_uart_event   stimulus_q[$];
    t_reg_snapshot responses_due[$];

    // Bookkeeping shared between the driver, the receiver and the monitor.
    logic        in_taken       = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned hold_cycles    = 0;
    logic        long_hold_done = 1'b0;
    int unsigned items_total    = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned n_reads        = 0;
    int unsigned n_writes       = 0;
    int unsigned n_rx           = 0;
    int unsigned n_tx_done      = 0;
    int unsigned n_handoffs     = 0;
    int unsigned n_irq_high     = 0;

    // Interrupt identification by priority: line status, then received data,
    // then transmitter holding register empty.
    function automatic logic [2:0] irq_code();
        if (ier_q[IER_RLS_BIT] && (err_q != '0)) begin
            return IIR_RLS;
        end
        if (ier_q[IER_RDA_BIT] && rx_ready) begin
            return IIR_RDA;
        end
        if (ier_q[IER_THRE_BIT] && thre_int) begin
            return IIR_THRE;
        end
        return IIR_NONE;
    endfunction

    // Line status: data ready, the four error flags, THRE and TEMT; bit 7 is zero.
    function automatic logic [7:0] line_status();
        logic thre;
        logic temt;
        thre = !thr_full;
        temt = thre && !shifter_busy;
        return {1'b0, temt, thre, err_q, rx_ready};
    endfunction

    // Applies one accepted transaction to the model and returns the result the
    // block must report for it.
    function automatic t_reg_snapshot apply_uart_event(input t_uart_event ev);
        t_reg_snapshot r;
        logic          dlab;
        logic [3:0]    new_ier;
        logic [2:0]    code;
        r = '{default: '0};
        dlab = lcr_q[LCR_DLAB_BIT];
        case (ev.cmd)
            CMD_READ: begin
                case (ev.offset)
                    OFF_RBR_THR: begin
                        if (dlab) begin
                            r.rdata = dll_q;
                        end else begin
                            // Reading with no data returns the stale byte.
                            r.rdata  = rbr_q;
                            rx_ready = 1'b0;
                        end
                    end
                    OFF_IER: r.rdata = dlab ? dlm_q : {4'b0, ier_q};
                    OFF_IIR_FCR: begin
                        code    = irq_code();
                        r.rdata = {5'b0, code};
                        if (code == IIR_THRE) begin
                            thre_int = 1'b0;
                        end
                    end
                    OFF_LCR: r.rdata = lcr_q;
                    OFF_MCR: r.rdata = {3'b0, mcr_q};
                    OFF_LSR: begin
                        r.rdata = line_status();
                        err_q   = '0;
                    end
                    OFF_MSR: r.rdata = '0;
                    default: r.rdata = scr_q;
                endcase
            end
            CMD_WRITE: begin
                case (ev.offset)
                    OFF_RBR_THR: begin
                        if (dlab) begin
                            dll_q = ev.wdata;
                        end else begin
                            // A write while full overwrites the held byte.
                            thr_q    = ev.wdata;
                            thr_full = 1'b1;
                            thre_int = 1'b0;
                            if (!shifter_busy) begin
                                r.tx_start   = 1'b1;
                                r.tx_byte    = thr_q;
                                shifter_busy = 1'b1;
                                thr_full     = 1'b0;
                                thre_int     = 1'b1;
                            end
                        end
                    end
                    OFF_IER: begin
                        if (dlab) begin
                            dlm_q = ev.wdata;
                        end else begin
                            new_ier = ev.wdata[3:0];
                            // Turning the THRE enable on with THR empty raises it at once.
                            if (new_ier[IER_THRE_BIT] && !ier_q[IER_THRE_BIT] &&
                                !thr_full) begin
                                thre_int = 1'b1;
                            end
                            ier_q = new_ier;
                        end
                    end
                    OFF_LCR: lcr_q = ev.wdata;
                    OFF_MCR: mcr_q = ev.wdata[4:0];
                    OFF_SCR: scr_q = ev.wdata;
                    default: ;
                endcase
            end
            CMD_RX: begin
                if (rx_ready) begin
                    err_q[ERR_OVERRUN] = 1'b1;
                end
                if (ev.rx_parity) begin
                    err_q[ERR_PARITY] = 1'b1;
                end
                if (ev.rx_framing) begin
                    err_q[ERR_FRAMING] = 1'b1;
                end
                if (ev.rx_brk) begin
                    err_q[ERR_BREAK] = 1'b1;
                end
                rbr_q    = ev.rx_byte;
                rx_ready = 1'b1;
            end
            default: begin
                // Transmitter finished: hand over a held byte or go idle.
                if (shifter_busy) begin
                    if (thr_full) begin
                        r.tx_start = 1'b1;
                        r.tx_byte  = thr_q;
                        thr_full   = 1'b0;
                        thre_int   = 1'b1;
                    end else begin
                        shifter_busy = 1'b0;
                    end
                end
            end
        endcase
        r.irq         = (irq_code() != IIR_NONE);
        r.divisor     = {dlm_q, dll_q};
        r.line_format = lcr_q[6:0];
        return r;
    endfunction

    // Shorthands for building the directed sequence.
    function automatic t_uart_event bus_read(input logic [2:0] offset);
        t_uart_event ev;
        ev = '{cmd: CMD_READ, offset: offset, default: '0};
        return ev;
    endfunction

    function automatic t_uart_event bus_write(input logic [2:0] offset, input logic [7:0] data);
        t_uart_event ev;
        ev = '{cmd: CMD_WRITE, offset: offset, wdata: data, default: '0};
        return ev;
    endfunction

    function automatic t_uart_event line_rx(input logic [7:0] data, input logic pe,
                                            input logic fe, input logic bi);
        t_uart_event ev;
        ev = '{cmd: CMD_RX, rx_byte: data, rx_parity: pe, rx_framing: fe, rx_brk: bi,
               default: '0};
        return ev;
    endfunction

    function automatic t_uart_event tx_finished();
        t_uart_event ev;
        ev = '{cmd: CMD_TX_DONE, default: '0};
        return ev;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endtask

    // Sender. Inputs change on the falling edge. A transaction that was not
    // taken at the last rising edge stays on the bus untouched; otherwise the
    // sender either idles for a burst or puts up the next queued transaction.
    always @(negedge i_clk) begin
        t_uart_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // Stalled: hold everything.
        end else if (send_gap != 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (stimulus_q.size() != 0) begin
            ev = stimulus_q.pop_front();
            i_cmd              <= ev.cmd;
            i_reg_offset       <= ev.offset;
            i_wdata            <= ev.wdata;
            i_rx_byte          <= ev.rx_byte;
            i_rx_parity_error  <= ev.rx_parity;
            i_rx_framing_error <= ev.rx_framing;
            i_rx_break         <= ev.rx_brk;
            i_in_valid         <= 1'b1;
            // An idle burst sometimes starts after this transaction, except near the end.
            if (stimulus_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(1, 13);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver. It stalls in random bursts, once for a long stretch to back the
    // block up, and not at all in the last part of the run.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles != 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (!long_hold_done && items_accepted >= LONG_HOLD_AT) begin
            i_out_stall    <= 1'b1;
            hold_cycles    <= LONG_HOLD_LEN - 1;
            long_hold_done <= 1'b1;
        end else if (stimulus_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor. On each rising edge an accepted input transaction is run through
    // the model first, then an accepted result is checked against the oldest
    // prediction. A result passes through the block's input and output
    // registers, so the order within the edge does not matter for matching.
    always @(posedge i_clk) begin
        t_uart_event   ev;
        t_reg_snapshot want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                ev.cmd        = t_cmd'(i_cmd);
                ev.offset     = i_reg_offset;
                ev.wdata      = i_wdata;
                ev.rx_byte    = i_rx_byte;
                ev.rx_parity  = i_rx_parity_error;
                ev.rx_framing = i_rx_framing_error;
                ev.rx_brk     = i_rx_break;
                responses_due.push_back(apply_uart_event(ev));
                items_accepted++;
                case (ev.cmd)
                    CMD_READ:  n_reads++;
                    CMD_WRITE: n_writes++;
                    CMD_RX:    n_rx++;
                    default:   n_tx_done++;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (responses_due.size() == 0) begin
                    $error("result transaction arrived with no prediction outstanding");
                    error_count++;
                end else begin
                    want = responses_due.pop_front();
                    check_field("rdata", 16'(want.rdata), 16'(o_rdata));
                    check_field("irq", 16'(want.irq), 16'(o_irq));
                    check_field("tx_start", 16'(want.tx_start), 16'(o_tx_start));
                    check_field("tx_byte", 16'(want.tx_byte), 16'(o_tx_byte));
                    check_field("divisor", want.divisor, o_divisor);
                    check_field("line_format", 16'(want.line_format), 16'(o_line_format));
                    if (want.tx_start) begin
                        n_handoffs++;
                    end
                    if (want.irq) begin
                        n_irq_high++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        t_uart_event ev;
        int unsigned pick;

        // Directed opening: reset values, the transmit hand-off and its corner
        // cases, overrun with all error flags, the interrupt priorities and the
        // side effects of reading, the divisor latch at its extremes and the
        // registers that ignore or trim writes.
        stimulus_q.push_back(bus_read(OFF_LSR));            // THRE and TEMT after reset
        stimulus_q.push_back(bus_read(OFF_RBR_THR));        // no data: stale byte
        stimulus_q.push_back(bus_write(OFF_IER, 8'hFF));    // trimmed, THRE enable raises irq
        stimulus_q.push_back(bus_read(OFF_IER));
        stimulus_q.push_back(bus_read(OFF_IIR_FCR));        // THRE code clears itself
        stimulus_q.push_back(bus_write(OFF_RBR_THR, 8'hA5)); // shifter idle: straight through
        stimulus_q.push_back(bus_write(OFF_RBR_THR, 8'h5A)); // shifter busy: held
        stimulus_q.push_back(bus_write(OFF_RBR_THR, 8'hFF)); // overwrites the held byte
        stimulus_q.push_back(bus_read(OFF_LSR));
        stimulus_q.push_back(tx_finished());                // held byte moves on
        stimulus_q.push_back(tx_finished());                // shifter goes idle
        stimulus_q.push_back(tx_finished());                // ignored while idle
        stimulus_q.push_back(line_rx(8'h00, 1'b1, 1'b1, 1'b1));
        stimulus_q.push_back(line_rx(8'hFF, 1'b0, 1'b0, 1'b0)); // overrun
        stimulus_q.push_back(bus_read(OFF_IIR_FCR));        // line status wins
        stimulus_q.push_back(bus_read(OFF_LSR));            // clears the errors
        stimulus_q.push_back(bus_read(OFF_IIR_FCR));        // now received data
        stimulus_q.push_back(bus_read(OFF_RBR_THR));
        stimulus_q.push_back(bus_write(OFF_LCR, 8'h80));    // open the divisor latch
        stimulus_q.push_back(bus_write(OFF_RBR_THR, 8'hFF));
        stimulus_q.push_back(bus_write(OFF_IER, 8'hFF));
        stimulus_q.push_back(bus_read(OFF_IER));
        stimulus_q.push_back(bus_write(OFF_LCR, 8'h7F));
        stimulus_q.push_back(bus_write(OFF_MCR, 8'hFF));    // only five bits stick
        stimulus_q.push_back(bus_write(OFF_LSR, 8'hFF));    // ignored
        stimulus_q.push_back(bus_read(OFF_MSR));
        stimulus_q.push_back(bus_write(OFF_SCR, 8'hFF));

        // Random part. Every field is random on every transaction, the command
        // mix favors bus accesses, and LCR writes open the divisor latch only a
        // quarter of the time so that THR, IER and RBR still see plenty of use.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick          = $urandom_range(0, 99);
            ev.cmd        = (pick < 35) ? CMD_READ : (pick < 70) ? CMD_WRITE :
                            (pick < 85) ? CMD_RX : CMD_TX_DONE;
            ev.offset     = 3'($urandom_range(0, 7));
            ev.wdata      = 8'($urandom_range(0, 255));
            ev.rx_byte    = 8'($urandom_range(0, 255));
            ev.rx_parity  = ($urandom_range(0, 3) == 0);
            ev.rx_framing = ($urandom_range(0, 3) == 0);
            ev.rx_brk     = ($urandom_range(0, 5) == 0);
            if (ev.cmd == CMD_WRITE && ev.offset == OFF_LCR) begin
                ev.wdata[LCR_DLAB_BIT] = ($urandom_range(0, 3) == 0);
            end
            stimulus_q.push_back(ev);
        end
        items_total = stimulus_q.size();

        // Reset is synchronous; release it on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to go in and every result to come out.
        while (items_accepted < items_total) begin
            @(posedge i_clk);
        end
        while (responses_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions: %0d reads, %0d writes, %0d received bytes,",
                 items_accepted, n_reads, n_writes, n_rx);
        $display("%0d transmit-done events; checked %0d results, %0d hand-offs, %0d with irq high.",
                 n_tx_done, results_seen, n_handoffs, n_irq_high);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
